>>> rtl/bde_pkg.sv
// Shared types, sizes and codes for the bounded deque engine.
// No dependencies; every other file imports this package.
package bde_pkg;

   localparam int unsigned DEPTH       = 64;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned COUNT_W     = $clog2(DEPTH + 1);
   localparam int unsigned COUNT_OUT_W = 7;

   // The back-word reduction ORs groups of eight cells per registered level.
   localparam int unsigned GROUP       = 8;
   localparam int unsigned GROUP_BITS  = 3;
   localparam int unsigned TREE_LEVELS = ($clog2(DEPTH) + GROUP_BITS - 1) / GROUP_BITS;
   localparam int unsigned WAIT_W      = $clog2(TREE_LEVELS + 1);

   typedef logic signed [WORD_W-1:0] word_type;

   typedef enum logic [1:0] {
      MODE_PUSH_FRONT = 2'd0,
      MODE_PUSH_BACK  = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_POP_BACK   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // One operation as seen by every cell of the chain.
   typedef struct packed {
      logic push_front;
      logic push_back;
      logic pop_front;
      logic pop_back;
   } cmd_type;

   // Number of nodes at a given level of the reduction tree; level 0 is the cells.
   function automatic int unsigned level_width(input int unsigned level);
      return (DEPTH + (1 << (GROUP_BITS * level)) - 1) >> (GROUP_BITS * level);
   endfunction

endpackage

>>> rtl/bde_cell.sv
// One storage cell of the deque chain: a word and its valid flag.
// Depends on bde_pkg; its neighbours are wired by the top level.
module bde_cell import bde_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  logic     prev_valid,
   input  word_type prev_word,
   input  logic     next_valid,
   input  word_type next_word,
   input  word_type push_word,
   output logic     valid,
   output word_type word,
   output word_type tail_word
);

   logic     valid_ff, valid_in;
   word_type word_ff, word_in;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      priority if (cmd.push_front) begin
         valid_in = prev_valid;
         word_in  = prev_word;
      end else if (cmd.push_back) begin
         // The first empty cell behind the last occupied one takes the word.
         if (!valid_ff && prev_valid) begin
            valid_in = 1'b1;
            word_in  = push_word;
         end
      end else if (cmd.pop_front) begin
         valid_in = next_valid;
         word_in  = next_word;
      end else if (cmd.pop_back) begin
         if (valid_ff && !next_valid) begin
            valid_in = 1'b0;
         end
      end else begin
         // No operation this cycle: the cell holds its contents.
         valid_in = valid_ff;
         word_in  = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign valid     = valid_ff;
   assign word      = word_ff;
   assign tail_word = (valid_ff && !next_valid) ? word_ff : '0;

endmodule

>>> rtl/bde_or_tree.sv
// Registered OR tree that gathers the word of the last occupied cell.
// Depends on bde_pkg; each level of the tree is registered.
module bde_or_tree import bde_pkg::*; (
   input  logic     clock,
   input  word_type leaf_word [DEPTH],
   output word_type root_word
);

   word_type tree_ff [TREE_LEVELS][DEPTH];

   function automatic word_type group_or(input word_type vec [DEPTH],
                                         input int unsigned base,
                                         input int unsigned limit);
      word_type acc;
      acc = '0;
      for (int unsigned k = 0; k < GROUP; k++) begin
         if (base + k < limit) begin
            acc = acc | vec[base + k];
         end
      end
      return acc;
   endfunction

   for (genvar l = 0; l < TREE_LEVELS; l++) begin : g_level
      word_type src [DEPTH];

      if (l == 0) begin : g_leaf
         assign src = leaf_word;
      end else begin : g_inner
         assign src = tree_ff[l-1];
      end

      always_ff @(posedge clock) begin
         for (int unsigned j = 0; j < DEPTH; j++) begin
            if (j < level_width(l + 1)) begin
               tree_ff[l][j] <= group_or(src, j * GROUP, level_width(l));
            end else begin
               tree_ff[l][j] <= '0;
            end
         end
      end
   end

   assign root_word = tree_ff[TREE_LEVELS-1][0];

endmodule

>>> rtl/bounded_deque_engine_unit.sv
// Top level of the bounded deque engine: a chain of storage cells plus control.
// Depends on bde_pkg, bde_cell and bde_or_tree.
//
// Usage. The request channel (req_valid, req_ready, req_mode, req_data_value)
// carries one operation per transaction: push front, push back, pop front or
// pop back. Every request gives exactly one response transaction on the
// rsp_ channel with the status, the removed word, the entry count and the
// words now at the front and the back of the queue.
// The front word sits in the first cell of the chain. The back word is found
// by a registered OR tree over the cells, with one level per eight-fold fan-in
// (two levels for 64 entries), so the response is valid only after a wait
// state that lets the tree settle. One operation is in flight at a time: the
// next request is taken the cycle after the response transaction. While the
// receiver holds rsp_ready low the response is held unchanged and req_ready
// stays low. A synchronous reset empties the queue at once; the block accepts
// a request in the first cycle after reset.
module bounded_deque_engine_unit import bde_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_mode,
   input  logic signed [31:0]     req_data_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic signed [31:0]     rsp_removed_value,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count,
   output logic signed [31:0]     rsp_front_value,
   output logic signed [31:0]     rsp_back_value
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT,
      ST_RESP
   } state_type;

   state_type          state_ff, state_in;
   logic [WAIT_W-1:0]  wait_ff, wait_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   status_type         status_ff, status_in;
   word_type           removed_ff, removed_in;

   cmd_type  cmd;
   logic     accept;
   logic     is_full;
   logic     is_empty;
   word_type back_word;

   logic     cell_valid [DEPTH];
   word_type cell_word  [DEPTH];
   word_type tail_word  [DEPTH];
   logic     left_valid [DEPTH];
   word_type left_word  [DEPTH];
   logic     right_valid [DEPTH];
   word_type right_word  [DEPTH];

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_full   = (count_ff == COUNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);

   // Neighbour wiring: a word pushed at the front enters from the front end of the chain.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_valid[i] = 1'b1;
         assign left_word[i]  = req_data_value;
      end else begin : g_body
         assign left_valid[i] = cell_valid[i-1];
         assign left_word[i]  = cell_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_valid[i] = 1'b0;
         assign right_word[i]  = '0;
      end else begin : g_inner
         assign right_valid[i] = cell_valid[i+1];
         assign right_word[i]  = cell_word[i+1];
      end

      bde_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_valid (left_valid[i]),
         .prev_word  (left_word[i]),
         .next_valid (right_valid[i]),
         .next_word  (right_word[i]),
         .push_word  (req_data_value),
         .valid      (cell_valid[i]),
         .word       (cell_word[i]),
         .tail_word  (tail_word[i])
      );
   end

   bde_or_tree u_or_tree (
      .clock     (clock),
      .leaf_word (tail_word),
      .root_word (back_word)
   );

   // The tree output is still the current back word while idle, so a pop from
   // the back reads it before the chain changes.
   always_comb begin
      cmd        = '0;
      count_in   = count_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      state_in   = state_ff;
      wait_in    = wait_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in  = STATUS_OK;
               removed_in = '0;
               state_in   = ST_WAIT;
               wait_in    = WAIT_W'(TREE_LEVELS - 1);
               unique case (mode_type'(req_mode))
                  MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                     if (is_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        cmd.push_front = (mode_type'(req_mode) == MODE_PUSH_FRONT);
                        cmd.push_back  = (mode_type'(req_mode) == MODE_PUSH_BACK);
                        count_in       = count_ff + 1'b1;
                     end
                  end
                  MODE_POP_FRONT: begin
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        cmd.pop_front = 1'b1;
                        removed_in    = cell_word[0];
                        count_in      = count_ff - 1'b1;
                     end
                  end
                  MODE_POP_BACK: begin
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        cmd.pop_back = 1'b1;
                        removed_in   = back_word;
                        count_in     = count_ff - 1'b1;
                     end
                  end
                  default: begin
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end
         ST_WAIT: begin
            if (wait_ff == '0) begin
               state_in = ST_RESP;
            end else begin
               wait_in = wait_ff - 1'b1;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         count_ff <= count_in;
      end
      status_ff  <= status_in;
      removed_ff <= removed_in;
   end

   assign rsp_valid         = (state_ff == ST_RESP);
   assign rsp_status        = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_entry_count   = COUNT_OUT_W'(count_ff);
   assign rsp_front_value   = is_empty ? '0 : cell_word[0];
   assign rsp_back_value    = is_empty ? '0 : back_word;

endmodule

>>> verif/tb_bounded_deque_engine_unit.sv
// Self-checking testbench for bounded_deque_engine_unit: random and directed deque operations,
// with the outcome of each predicted by a ring-buffer model held here and checked on rsp_.
// Depends on bde_pkg and the bounded_deque_engine_unit RTL.
module tb_bounded_deque_engine_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import bde_pkg::*;

   typedef struct {
      mode_type    mode;
      word_type    value;
      int unsigned gap;
   } deque_op_type;

   typedef struct {
      status_type             status;
      word_type               removed;
      logic [COUNT_OUT_W-1:0] count;
      word_type               front;
      word_type               back;
   } deque_outcome_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [1:0]             req_mode;
   logic signed [31:0]     req_data_value;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [1:0]             rsp_status;
   logic signed [31:0]     rsp_removed_value;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;
   logic signed [31:0]     rsp_front_value;
   logic signed [31:0]     rsp_back_value;

   deque_op_type      pending_ops[$];
   deque_outcome_type expected_outcomes[$];
   deque_outcome_type oldest;
   deque_op_type      next_op;

   // Shadow of the queue contents.
   word_type    ring_words[DEPTH];
   int unsigned ring_head = 0;
   int unsigned ring_tail = 0;
   int unsigned ring_fill = 0;

   int  mismatch_count = 0;
   bit  req_accepted   = 1'b0;
   bit  rsp_accepted   = 1'b0;
   bit  req_holding    = 1'b0;
   bit  rsp_busy       = 1'b1;
   int  gap_left       = -1;
   int  stall_left     = 0;

   bounded_deque_engine_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_data_value    (req_data_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_front_value   (rsp_front_value),
      .rsp_back_value    (rsp_back_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned ring_prev(input int unsigned idx);
      return (idx == 0) ? DEPTH - 1 : idx - 1;
   endfunction

   function automatic int unsigned ring_next(input int unsigned idx);
      return (idx + 1 >= DEPTH) ? 0 : idx + 1;
   endfunction

   // Applies one operation to the shadow queue and returns the response it should give.
   function automatic deque_outcome_type deque_apply(input mode_type op,
                                                     input word_type value);
      deque_outcome_type r;
      r.status  = STATUS_OK;
      r.removed = '0;
      r.front   = '0;
      r.back    = '0;
      case (op)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (ring_fill >= DEPTH) begin
               r.status = STATUS_FULL;
            end else if (op == MODE_PUSH_FRONT) begin
               ring_head = ring_prev(ring_head);
               ring_words[ring_head] = value;
               ring_fill++;
            end else begin
               ring_words[ring_tail] = value;
               ring_tail = ring_next(ring_tail);
               ring_fill++;
            end
         end
         default: begin
            if (ring_fill == 0) begin
               r.status = STATUS_EMPTY;
            end else if (op == MODE_POP_FRONT) begin
               r.removed = ring_words[ring_head];
               ring_head = ring_next(ring_head);
               ring_fill--;
            end else begin
               ring_tail = ring_prev(ring_tail);
               r.removed = ring_words[ring_tail];
               ring_fill--;
            end
         end
      endcase
      if (ring_fill != 0) begin
         r.front = ring_words[ring_head];
         r.back  = ring_words[ring_prev(ring_tail)];
      end
      r.count = COUNT_OUT_W'(ring_fill);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic add_op(input mode_type op, input word_type value, input int unsigned gap);
      deque_op_type item;
      item.mode  = op;
      item.value = value;
      item.gap   = gap;
      pending_ops.push_back(item);
   endtask

   // Mostly uniform words, with the signed extremes, zero and minus one mixed in.
   function automatic word_type random_word();
      case ($urandom_range(0, 15))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return 32'sh0000_0000;
         3:       return -32'sd1;
         default: return word_type'($urandom);
      endcase
   endfunction

   // Monitor: check responses first, then record the transaction accepted on req_.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_accepted = 1'b1;
            if (expected_outcomes.size() == 0) begin
               report_mismatch("response with nothing outstanding", 32'(rsp_status), '0);
            end else begin
               oldest = expected_outcomes.pop_front();
               if (rsp_status !== oldest.status)
                  report_mismatch("status", 32'(rsp_status), 32'(oldest.status));
               if (rsp_removed_value !== oldest.removed)
                  report_mismatch("removed_value", rsp_removed_value, oldest.removed);
               if (rsp_entry_count !== oldest.count)
                  report_mismatch("entry_count", 32'(rsp_entry_count), 32'(oldest.count));
               if (rsp_front_value !== oldest.front)
                  report_mismatch("front_value", rsp_front_value, oldest.front);
               if (rsp_back_value !== oldest.back)
                  report_mismatch("back_value", rsp_back_value, oldest.back);
            end
         end
         if (req_valid && req_ready) begin
            req_accepted = 1'b1;
            expected_outcomes.push_back(deque_apply(mode_type'(req_mode), req_data_value));
         end
      end
   end

   // Request driver: each item waits out its own gap before valid is raised.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_accepted) begin
            req_accepted = 1'b0;
            req_holding  = 1'b0;
         end
         if (!req_holding && pending_ops.size() != 0) begin
            if (gap_left < 0) gap_left = pending_ops[0].gap;
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               next_op = pending_ops.pop_front();
               req_mode       <= next_op.mode;
               req_data_value <= next_op.value;
               req_holding = 1'b1;
               gap_left    = -1;
            end
         end
         req_valid <= req_holding;
      end
   end

   // Response receiver: stalls a random number of cycles after each transaction,
   // switching now and then between a stalling and a free-running regime.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_accepted) begin
            rsp_accepted = 1'b0;
            if ($urandom_range(0, 49) == 0) rsp_busy = !rsp_busy;
            stall_left = rsp_busy ? $urandom_range(0, 10) : 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int          random_items;
      int          burst_len;
      int          push_pct;
      int unsigned gap_max;
      mode_type    op;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = MODE_PUSH_FRONT;
      req_data_value = '0;
      rsp_ready      = 1'b0;

      // Directed: pops of an empty queue, extreme words at both ends, mixed removal.
      add_op(MODE_POP_FRONT,  random_word(), 0);
      add_op(MODE_POP_BACK,   random_word(), 3);
      add_op(MODE_PUSH_BACK,  32'sh7fff_ffff, 0);
      add_op(MODE_PUSH_FRONT, 32'sh8000_0000, 0);
      add_op(MODE_POP_BACK,   random_word(), 1);
      add_op(MODE_POP_FRONT,  random_word(), 0);
      add_op(MODE_POP_FRONT,  random_word(), 0);
      add_op(MODE_PUSH_BACK,  32'sh0000_0000, 0);
      add_op(MODE_PUSH_BACK,  -32'sd1, 10);
      add_op(MODE_PUSH_FRONT, 32'sh5555_aaaa, 0);
      add_op(MODE_PUSH_FRONT, 32'shaaaa_5555, 2);
      add_op(MODE_POP_BACK,   random_word(), 0);
      add_op(MODE_POP_FRONT,  random_word(), 0);
      add_op(MODE_POP_BACK,   random_word(), 0);
      add_op(MODE_POP_FRONT,  random_word(), 0);
      add_op(MODE_POP_BACK,   random_word(), 0);
      add_op(MODE_PUSH_FRONT, 32'sh0000_0001, 0);
      add_op(MODE_POP_BACK,   random_word(), 0);

      // Random bursts, each with its own push bias, so the queue swings between
      // full and empty. The first two bursts fill it and drain it again.
      random_items = 0;
      while (random_items < 1550) begin
         burst_len = $urandom_range(40, 200);
         case (random_items == 0 ? 0 : $urandom_range(0, 4))
            0:       push_pct = 90;
            1:       push_pct = 10;
            2:       push_pct = 50;
            default: push_pct = $urandom_range(0, 100);
         endcase
         if (random_items == 0) burst_len = 180;
         else if (random_items == 180) begin
            push_pct  = 10;
            burst_len = 180;
         end
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
         repeat (burst_len) begin
            if ($urandom_range(0, 99) < push_pct)
               op = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
            else
               op = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
            add_op(op, random_word(), $urandom_range(0, gap_max));
         end
         random_items += burst_len;
      end

      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_ops.size() != 0 || req_holding) @(posedge clock);
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (TREE_LEVELS + 6) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("bounded_deque_engine_unit verification clean");
      end else begin
         $display("bounded_deque_engine_unit verification failed");
      end
      $finish;
   end

   // Fewer than two thousand items fit well inside this.
   initial begin
      #3_000_000;
      $display("bounded_deque_engine_unit verification failed");
      $finish;
   end

endmodule
